>>> design/fbpa_pkg.sv
// Shared constants and codes for the fixed block pool allocator.
// Used by the divider and the top level; depends on nothing.
package fbpa_pkg;

    localparam int ADDR_W             = 48;
    localparam int SIZE_W             = 16;
    localparam int SLOTS_CFG_W        = 11;
    localparam int DEF_SLOT_COUNT     = 1024;
    localparam int DEF_ADDRESS_BITS   = 48;

    localparam logic [ADDR_W-1:0]      RST_POOL_BASE = 48'd4096;
    localparam logic [SIZE_W-1:0]      RST_SLOT_SIZE = 16'd64;
    localparam logic [SLOTS_CFG_W-1:0] RST_SLOTS     = 11'd1024;

    typedef enum logic [1:0] {
        CFG_POOL_BASE = 2'd0,
        CFG_SLOT_SIZE = 2'd1,
        CFG_SLOTS     = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_REBUILD = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_NOT_OWNED = 2'd2,
        STS_REBUILT   = 2'd3
    } status_t;

endpackage

>>> design/fbpa_link_ram.sv
// Free-list link memory: one write port, one read port, registered read data.
// Standalone; no package dependency.
module fbpa_link_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> design/fbpa_divider.sv
// Restoring divider, one quotient bit per cycle, for the release ownership check.
// Depends on fbpa_pkg for the slot size width.
module fbpa_divider
    import fbpa_pkg::*;
#(
    parameter int QW = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SIZE_W+QW-1:0] dividend,
    input  logic [SIZE_W-1:0]    divisor,
    output logic                 done,
    output logic [QW-1:0]        quotient,
    output logic [SIZE_W+QW-1:0] remainder
);

    localparam int DW = SIZE_W + QW;
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dsr_reg;
    logic [QW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          ge;

    assign ge = rem_reg >= dsr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dsr_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= dividend;
                dsr_reg  <= DW'(divisor) << (QW - 1);
                q_reg    <= '0;
                cnt_reg  <= CW'(QW - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsr_reg;
                end
                q_reg   <= (q_reg << 1) | QW'(ge);
                dsr_reg <= dsr_reg >> 1;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

>>> design/fixed_block_pool_allocator_unit.sv
// Fixed block pool allocator top: config registers, control sequencer, link RAM, divider.
// out_valid is set from ST_ALLOC for allocate; release goes through ST_REL_CHK, ST_REL_DIV
// (one-bit-per-cycle divider, skipped if not owned), ST_REL_FIN; rebuild sweeps the link RAM.
// One item at a time; the next transfer is taken while a result waits on the output.
// After reset a sweep initializes every link RAM entry with in_ready low.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        action,
    input  logic [ADDR_W-1:0]                 release_address,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [ADDR_W-1:0]                 slot_address,
    output logic [$clog2(SLOT_COUNT)-1:0]     slot_index,
    output logic [$clog2(SLOT_COUNT+1)-1:0]   live_count,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [ADDR_W-1:0]                 cfg_data
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int LINK_W = $clog2(SLOT_COUNT + 1);
    localparam int PROD_W = LINK_W + SIZE_W;
    localparam int DIV_W  = SIZE_W + IDX_W;
    localparam int EXT_W  = ADDR_W + 2;
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
        : ((ADDR_W'(1) << ADDRESS_BITS) - ADDR_W'(1));

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_REL_CHK,
        ST_REL_DIV,
        ST_REL_FIN,
        ST_REBUILT
    } state_t;

    // configuration
    logic [ADDR_W-1:0]      base_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [SLOTS_CFG_W-1:0] slots_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= RST_POOL_BASE;
            size_reg  <= RST_SLOT_SIZE;
            slots_reg <= RST_SLOTS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POOL_BASE: base_reg  <= cfg_data;
                CFG_SLOT_SIZE: size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SLOTS:     slots_reg <= cfg_data[SLOTS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective slot count, clamped to 1..SLOT_COUNT
    logic [31:0]       n_wide;
    logic [LINK_W-1:0] n_act;

    always_comb
    begin
        n_wide = 32'(slots_reg);
        if (n_wide == 32'd0)
        begin
            n_wide = 32'd1;
        end
        else if (n_wide > 32'(SLOT_COUNT))
        begin
            n_wide = 32'(SLOT_COUNT);
        end
        n_act = LINK_W'(n_wide);
    end

    state_t              state_reg,      state_next;
    logic [LINK_W-1:0]   head_reg,       head_next;
    logic [LINK_W-1:0]   live_reg,       live_next;
    logic [LINK_W-1:0]   clr_cnt_reg,    clr_cnt_next;
    logic                rebuild_reg,    rebuild_next;
    logic                empty_reg,      empty_next;
    logic                bad_reg,        bad_next;
    logic [PROD_W-1:0]   prod_reg,       prod_next;
    logic [ADDR_W-1:0]   addr_reg,       addr_next;
    logic                out_valid_reg,  out_valid_next;
    status_t             status_reg,     status_next;
    logic [ADDR_W-1:0]   slot_addr_reg,  slot_addr_next;
    logic [IDX_W-1:0]    slot_idx_reg,   slot_idx_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [LINK_W-1:0] mem_rdata;

    logic              div_start;
    logic              div_done;
    logic [IDX_W-1:0]  div_q;
    logic [DIV_W-1:0]  div_rem;
    logic [DIV_W-1:0]  div_dividend;

    logic              out_free;
    logic [LINK_W-1:0] mul_a;
    logic [EXT_W-1:0]  end_sum;
    logic              owned;

    assign out_free     = !out_valid_reg || out_ready;
    assign end_sum      = {2'b00, base_reg} + EXT_W'(prod_reg);
    assign owned        = (addr_reg != '0) && (size_reg != '0) && (addr_reg >= base_reg)
                          && ({2'b00, addr_reg} < end_sum);
    assign div_dividend = DIV_W'(addr_reg - base_reg);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        live_next      = live_reg;
        clr_cnt_next   = clr_cnt_reg;
        rebuild_next   = rebuild_reg;
        empty_next     = empty_reg;
        bad_next       = bad_reg;
        prod_next      = prod_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        slot_addr_next = slot_addr_reg;
        slot_idx_next  = slot_idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg[IDX_W-1:0];
        mem_wdata      = clr_cnt_reg + LINK_W'(1);
        mem_raddr      = head_reg[IDX_W-1:0];
        div_start      = 1'b0;
        mul_a          = head_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + LINK_W'(1);
                if (clr_cnt_reg == LINK_W'(SLOT_COUNT - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = rebuild_reg ? ST_REBUILT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mul_a     = (action == ACT_ALLOC) ? head_reg : n_act;
                    prod_next = PROD_W'(mul_a) * PROD_W'(size_reg);
                    addr_next = release_address;
                    unique case (action)
                        ACT_ALLOC:
                        begin
                            empty_next = head_reg >= n_act;
                            state_next = ST_ALLOC;
                        end
                        ACT_RELEASE:
                        begin
                            state_next = ST_REL_CHK;
                        end
                        ACT_REBUILD:
                        begin
                            head_next    = '0;
                            rebuild_next = 1'b1;
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ALLOC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (empty_reg)
                    begin
                        status_next    = STS_EMPTY;
                        slot_addr_next = '0;
                        slot_idx_next  = '0;
                    end
                    else
                    begin
                        status_next    = STS_DONE;
                        slot_addr_next = ADDR_W'(base_reg + ADDR_W'(prod_reg)) & ADDR_MASK;
                        slot_idx_next  = head_reg[IDX_W-1:0];
                        head_next      = mem_rdata;
                        if (live_reg != LINK_W'(SLOT_COUNT))
                        begin
                            live_next = live_reg + LINK_W'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_REL_CHK:
            begin
                if (owned)
                begin
                    bad_next   = 1'b0;
                    div_start  = 1'b1;
                    state_next = ST_REL_DIV;
                end
                else
                begin
                    bad_next   = 1'b1;
                    state_next = ST_REL_FIN;
                end
            end
            ST_REL_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_REL_FIN;
                end
            end
            ST_REL_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    slot_addr_next = '0;
                    if (bad_reg || (div_rem != '0))
                    begin
                        status_next   = STS_NOT_OWNED;
                        slot_idx_next = '0;
                    end
                    else
                    begin
                        status_next   = STS_DONE;
                        slot_idx_next = div_q;
                        mem_we        = 1'b1;
                        mem_waddr     = div_q;
                        mem_wdata     = head_reg;
                        head_next     = LINK_W'(div_q);
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - LINK_W'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_REBUILT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STS_REBUILT;
                    slot_addr_next = '0;
                    slot_idx_next  = '0;
                    live_next      = '0;
                    rebuild_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            head_reg      <= '0;
            live_reg      <= '0;
            clr_cnt_reg   <= '0;
            rebuild_reg   <= 1'b0;
            empty_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            prod_reg      <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STS_DONE;
            slot_addr_reg <= '0;
            slot_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            live_reg      <= live_next;
            clr_cnt_reg   <= clr_cnt_next;
            rebuild_reg   <= rebuild_next;
            empty_reg     <= empty_next;
            bad_reg       <= bad_next;
            prod_reg      <= prod_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            slot_addr_reg <= slot_addr_next;
            slot_idx_reg  <= slot_idx_next;
        end
    end

    fbpa_link_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fbpa_divider #(
        .QW (IDX_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (size_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot_address = slot_addr_reg;
    assign slot_index   = slot_idx_reg;
    assign live_count   = live_reg;

endmodule

>>> tb/tb.sv
// Self-checking testbench for fixed_block_pool_allocator_unit: directed table, then random phases.
// Checks stated table replies, else its own free-list predictor; depends on fbpa_pkg and the DUT.
module tb;
    import fbpa_pkg::*;

    localparam int          POOL_SLOTS      = DEF_SLOT_COUNT;
    localparam int          SETTLE_CYCLES   = 64;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          CYCLE_LIMIT     = 2_000_000;
    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 93;
    localparam logic [1:0]  ACT_UNUSED      = 2'd3;
    localparam logic [47:0] ADDR_MAX        = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] slot_address;
        logic [9:0]        slot_index;
        logic [10:0]       live_count;
    } pool_reply_t;

    typedef struct {
        bit          stated;
        pool_reply_t want;
    } table_reply_t;

    typedef struct {
        bit          is_reg;
        logic [1:0]  code;
        logic [47:0] value;
        bit          stated;
        pool_reply_t want;
    } plan_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               action;
    logic [ADDR_W-1:0]        release_address;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               status;
    logic [ADDR_W-1:0]        slot_address;
    logic [9:0]               slot_index;
    logic [10:0]              live_count;
    logic                     cfg_write;
    logic [1:0]               cfg_index;
    logic [ADDR_W-1:0]        cfg_data;

    int unsigned free_link [POOL_SLOTS];
    int unsigned head_slot;
    int unsigned live_total;
    logic [47:0] mdl_base;
    logic [15:0] mdl_size;
    logic [10:0] mdl_slots;

    pool_reply_t  pending_replies [$];
    table_reply_t table_replies [$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  hold_off_ask = 0;
    int unsigned  hold_off_done = 0;
    bit           calm = 1'b0;

    fixed_block_pool_allocator_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .release_address (release_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot_address    (slot_address),
        .slot_index      (slot_index),
        .live_count      (live_count),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned clamp_slots(input logic [10:0] slots);
        if (slots == 0)
            return 1;
        if (slots > POOL_SLOTS)
            return POOL_SLOTS;
        return slots;
    endfunction

    function automatic logic [47:0] slot_addr_of(input logic [47:0] base, input logic [15:0] size,
                                                 input int unsigned idx);
        return 48'(64'(base) + 64'(idx) * 64'(size));
    endfunction

    function automatic void relink_pool();
        for (int i = 0; i < POOL_SLOTS; i++)
            free_link[i] = i + 1;
        head_slot = 0;
        live_total = 0;
    endfunction

    function automatic bit pool_model_step(input logic [1:0] act, input logic [47:0] addr,
                                           output pool_reply_t res);
        int unsigned n;
        logic [63:0] base64, size64, addr64, pool_end, idx;
        n = clamp_slots(mdl_slots);
        base64 = 64'(mdl_base);
        size64 = 64'(mdl_size);
        addr64 = 64'(addr);
        res = '0;
        case (act)
            ACT_ALLOC:
            begin
                if (head_slot >= n)
                    res.status = STS_EMPTY;
                else
                begin
                    res.status = STS_DONE;
                    res.slot_address = slot_addr_of(mdl_base, mdl_size, head_slot);
                    res.slot_index = 10'(head_slot);
                    head_slot = free_link[head_slot];
                    if (live_total < POOL_SLOTS)
                        live_total++;
                end
            end
            ACT_RELEASE:
            begin
                pool_end = base64 + size64 * 64'(n);
                if (addr64 == 0 || size64 == 0 || addr64 < base64 || addr64 >= pool_end ||
                    ((addr64 - base64) % size64) != 0)
                    res.status = STS_NOT_OWNED;
                else
                begin
                    idx = (addr64 - base64) / size64;
                    if (idx < POOL_SLOTS)
                    begin
                        free_link[idx] = head_slot;
                        head_slot = 32'(idx);
                    end
                    res.status = STS_DONE;
                    res.slot_index = 10'(idx);
                    if (live_total > 0)
                        live_total--;
                end
            end
            ACT_REBUILD:
            begin
                relink_pool();
                res.status = STS_REBUILT;
            end
            default:
                return 1'b0;
        endcase
        res.live_count = 11'(live_total);
        return 1'b1;
    endfunction

    function automatic plan_row_t item_row(input logic [1:0] act, input logic [47:0] addr);
        plan_row_t r;
        r.is_reg = 1'b0;
        r.code = act;
        r.value = addr;
        r.stated = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t stated_row(input logic [1:0] act, input logic [47:0] addr,
                                             input logic [1:0] st, input logic [47:0] sa,
                                             input int unsigned si, input int unsigned lc);
        plan_row_t r;
        r = item_row(act, addr);
        r.stated = 1'b1;
        r.want = '{st, sa, 10'(si), 11'(lc)};
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [47:0] data);
        plan_row_t r;
        r = item_row(idx, data);
        r.is_reg = 1'b1;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic offer_request(input logic [1:0] act, input logic [47:0] addr,
                                 input bit stated, input pool_reply_t want);
        table_reply_t t;
        t.stated = stated;
        t.want = want;
        table_replies.push_back(t);
        in_valid <= 1'b1;
        action <= act;
        release_address <= addr;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic pause_sender();
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input pool_reply_t want, input pool_reply_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: want st=%0d addr=%h idx=%0d live=%0d, got st=%0d addr=%h idx=%0d live=%0d",
                     what, want.status, want.slot_address, want.slot_index, want.live_count,
                     got.status, got.slot_address, got.slot_index, got.live_count);
    endtask

    always @(posedge clk)
    begin
        pool_reply_t  got, want, predicted;
        table_reply_t stated;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{status, slot_address, slot_index, live_count};
                if (pending_replies.size() == 0)
                    note_mismatch("unexpected transfer", '0, got);
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status || got.slot_address !== want.slot_address ||
                        got.slot_index !== want.slot_index || got.live_count !== want.live_count)
                        note_mismatch("mismatch", want, got);
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_POOL_BASE: mdl_base = cfg_data;
                    CFG_SLOT_SIZE: mdl_size = cfg_data[15:0];
                    CFG_SLOTS:     mdl_slots = cfg_data[10:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                stated = table_replies.pop_front();
                if (pool_model_step(action, release_address, predicted))
                    pending_replies.push_back(stated.stated ? stated.want : predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned roll, span;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_ask != hold_off_done)
            begin
                hold_off_done = hold_off_ask;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (calm || roll < 60)
                    span = 0;
                else if (roll < 90)
                    span = $urandom_range(1, 3);
                else
                    span = $urandom_range(5, 40);
                out_ready <= (span == 0);
                repeat ((span == 0) ? $urandom_range(1, 8) : span) @(posedge clk);
            end
        end
    end

    initial
    begin
        plan_row_t   script [$];
        bit          last_was_item;
        int unsigned sent, roll, n_gen, idx_cap, slot_pick;
        logic [1:0]  act;
        logic [47:0] addr, owned;
        logic [47:0] gen_base;
        logic [15:0] gen_size;
        logic [10:0] gen_slots;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_ALLOC;
        release_address <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_POOL_BASE;
        cfg_data <= '0;
        mdl_base = RST_POOL_BASE;
        mdl_size = RST_SLOT_SIZE;
        mdl_slots = RST_SLOTS;
        relink_pool();

        script.push_back(stated_row(ACT_ALLOC, 48'd0, STS_DONE, 48'd4096, 0, 1));
        script.push_back(stated_row(ACT_ALLOC, ADDR_MAX, STS_DONE, 48'd4160, 1, 2));
        script.push_back(stated_row(ACT_RELEASE, 48'd0, STS_NOT_OWNED, 48'd0, 0, 2));
        script.push_back(stated_row(ACT_RELEASE, 48'd4128, STS_NOT_OWNED, 48'd0, 0, 2));
        script.push_back(stated_row(ACT_RELEASE, 48'd69632, STS_NOT_OWNED, 48'd0, 0, 2));
        script.push_back(stated_row(ACT_RELEASE, ADDR_MAX, STS_NOT_OWNED, 48'd0, 0, 2));
        script.push_back(stated_row(ACT_RELEASE, 48'd4160, STS_DONE, 48'd0, 1, 1));
        script.push_back(stated_row(ACT_RELEASE, 48'd4160, STS_DONE, 48'd0, 1, 0));
        script.push_back(stated_row(ACT_RELEASE, 48'd4160, STS_DONE, 48'd0, 1, 0));
        script.push_back(item_row(ACT_ALLOC, 48'd0));
        script.push_back(item_row(ACT_UNUSED, ADDR_MAX));
        script.push_back(stated_row(ACT_REBUILD, 48'd0, STS_REBUILT, 48'd0, 0, 0));
        script.push_back(stated_row(ACT_RELEASE, 48'd69568, STS_DONE, 48'd0, 1023, 0));
        script.push_back(stated_row(ACT_ALLOC, 48'd0, STS_DONE, 48'd69568, 1023, 1));
        script.push_back(reg_row(CFG_SLOTS, 48'd2));
        script.push_back(stated_row(ACT_REBUILD, 48'd0, STS_REBUILT, 48'd0, 0, 0));
        script.push_back(stated_row(ACT_ALLOC, 48'd0, STS_DONE, 48'd4096, 0, 1));
        script.push_back(stated_row(ACT_ALLOC, 48'd0, STS_DONE, 48'd4160, 1, 2));
        script.push_back(stated_row(ACT_ALLOC, 48'd0, STS_EMPTY, 48'd0, 0, 2));
        script.push_back(stated_row(ACT_RELEASE, 48'd4224, STS_NOT_OWNED, 48'd0, 0, 2));
        script.push_back(reg_row(CFG_SLOTS, 48'd0));
        script.push_back(stated_row(ACT_RELEASE, 48'd4096, STS_DONE, 48'd0, 0, 1));
        script.push_back(stated_row(ACT_ALLOC, 48'd0, STS_DONE, 48'd4096, 0, 2));
        script.push_back(reg_row(CFG_SLOT_SIZE, 48'd0));
        script.push_back(stated_row(ACT_RELEASE, 48'd4096, STS_NOT_OWNED, 48'd0, 0, 2));
        script.push_back(reg_row(CFG_POOL_BASE, ADDR_MAX));
        script.push_back(reg_row(CFG_SLOT_SIZE, 48'hFFFF));
        script.push_back(reg_row(CFG_SLOTS, 48'h7FF));
        script.push_back(stated_row(ACT_REBUILD, 48'd0, STS_REBUILT, 48'd0, 0, 0));
        script.push_back(stated_row(ACT_ALLOC, 48'd0, STS_DONE, ADDR_MAX, 0, 1));
        script.push_back(stated_row(ACT_ALLOC, 48'd0, STS_DONE, 48'hFFFE, 1, 2));
        script.push_back(stated_row(ACT_RELEASE, ADDR_MAX, STS_DONE, 48'd0, 0, 1));
        script.push_back(reg_row(CFG_POOL_BASE, 48'd1));
        script.push_back(reg_row(CFG_SLOT_SIZE, 48'd8));
        script.push_back(stated_row(ACT_RELEASE, 48'd1, STS_DONE, 48'd0, 0, 0));
        script.push_back(stated_row(ACT_RELEASE, 48'd9, STS_DONE, 48'd0, 1, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        last_was_item = 1'b0;
        foreach (script[k])
        begin
            if (script[k].is_reg)
            begin
                if (last_was_item)
                begin
                    in_valid <= 1'b0;
                    wait_idle();
                end
                write_reg(script[k].code, script[k].value);
                last_was_item = 1'b0;
            end
            else
            begin
                offer_request(script[k].code, script[k].value, script[k].stated, script[k].want);
                pause_sender();
                last_was_item = 1'b1;
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            in_valid <= 1'b0;
            wait_idle();
            case ($urandom_range(0, 7))
                0:       gen_base = 48'd1;
                1:       gen_base = ADDR_MAX;
                6, 7:    gen_base = 48'({$urandom, $urandom});
                default: gen_base = 48'(4096 * $urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 7))
                0:       gen_size = 16'd8;
                1:       gen_size = 16'hFFFF;
                6:       gen_size = 16'($urandom_range(0, 65535));
                7:       gen_size = 16'($urandom_range(0, 7));
                default: gen_size = 16'($urandom_range(8, 512));
            endcase
            case ($urandom_range(0, 7))
                4:       gen_slots = 11'd1024;
                5:       gen_slots = 11'h7FF;
                6:       gen_slots = 11'd0;
                7:       gen_slots = 11'($urandom_range(0, 2047));
                default: gen_slots = 11'($urandom_range(1, 12));
            endcase
            write_reg(CFG_POOL_BASE, gen_base);
            write_reg(CFG_SLOT_SIZE, 48'(gen_size));
            write_reg(CFG_SLOTS, 48'(gen_slots));
            n_gen = clamp_slots(gen_slots);
            idx_cap = (n_gen > 32) ? 31 : n_gen - 1;
            calm = (phase == 1 || phase == 2 || phase == 7);
            sent = 0;
            if ($urandom_range(0, 4) != 0)
            begin
                offer_request(ACT_REBUILD, 48'({$urandom, $urandom}), 1'b0, '0);
                pause_sender();
                sent++;
            end
            if (phase == 2)
                hold_off_ask++;
            while (sent < ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(0, 99);
                addr = 48'({$urandom, $urandom});
                slot_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_gen - 1)
                                                        : $urandom_range(0, idx_cap);
                owned = slot_addr_of(gen_base, gen_size, slot_pick);
                act = ACT_RELEASE;
                if (roll < 42)
                    act = ACT_ALLOC;
                else if (roll < 72)
                    addr = owned;
                else if (roll < 82)
                begin
                    case ($urandom_range(0, 3))
                        0:       addr = owned - 48'd1;
                        1:       addr = owned + 48'd1;
                        2:       addr = slot_addr_of(gen_base, gen_size, n_gen);
                        default: addr = 48'd0;
                    endcase
                end
                else if (roll < 92)
                    act = ACT_RELEASE;
                else if (roll < 95)
                    act = ACT_REBUILD;
                else
                    act = ACT_UNUSED;
                offer_request(act, addr, 1'b0, '0);
                pause_sender();
                if (act != ACT_UNUSED)
                    sent++;
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        wait_idle();
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
